// ===== design/ipdpc_pkg.sv =====
package ipdpc_pkg;

  localparam int ValueWidthDef = 32;

  localparam int DataW    = 32;
  localparam int DtW      = 16;
  localparam int CfgIdxW  = 2;

  // shared multiplier: 33 x 32 magnitude product
  localparam int MulAW    = 33;
  localparam int MulBW    = 32;
  localparam int ProdW    = 64;

  // shared restoring divider: quotient always below 2^31
  localparam int DivRemW  = 50;
  localparam int DivSteps = 31;
  localparam int DivCntW  = $clog2(DivSteps);

  localparam logic [DataW-1:0] KpReset  = 32'd589824;
  localparam logic [DataW-1:0] KdReset  = 32'd294912;
  localparam logic [DataW-1:0] StrReset = 32'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP       = 2'd0,
    CFG_KD       = 2'd1,
    CFG_STRENGTH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                start;
    logic [DivRemW-1:0]  rem;
    logic [DivSteps-1:0] num;
    logic [DivRemW-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic [DivSteps-1:0] quot;
  } div_sts_t;

endpackage

// ===== design/ipdpc_mul.sv =====
module ipdpc_mul (
  input  logic                            clk_i,
  input  logic [ipdpc_pkg::MulAW-1:0]     a_i,
  input  logic [ipdpc_pkg::MulBW-1:0]     b_i,
  output logic [ipdpc_pkg::ProdW-1:0]     prod_o
);

  logic [ipdpc_pkg::MulAW+ipdpc_pkg::MulBW-1:0] full;
  logic [ipdpc_pkg::ProdW-1:0]                  prod_q;

  assign full   = a_i * b_i;
  assign prod_o = prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= full[ipdpc_pkg::ProdW-1:0];
  end

endmodule

// ===== design/ipdpc_div.sv =====
module ipdpc_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ipdpc_pkg::div_req_t   req_i,
  output ipdpc_pkg::div_sts_t   sts_o
);

  logic [ipdpc_pkg::DivRemW-1:0]  rem_q;
  logic [ipdpc_pkg::DivSteps-1:0] num_q;
  logic [ipdpc_pkg::DivRemW-1:0]  den_q;
  logic [ipdpc_pkg::DivSteps-1:0] quo_q;
  logic [ipdpc_pkg::DivCntW-1:0]  cnt_q;
  logic                           busy_q;

  logic [ipdpc_pkg::DivRemW:0]    shifted;
  logic [ipdpc_pkg::DivRemW:0]    trial;
  logic                           qbit;

  assign shifted = {rem_q, num_q[ipdpc_pkg::DivSteps-1]};
  assign trial   = shifted - {1'b0, den_q};
  assign qbit    = !trial[ipdpc_pkg::DivRemW];

  assign sts_o.busy = busy_q;
  assign sts_o.quot = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= ipdpc_pkg::DivCntW'(ipdpc_pkg::DivSteps - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem;
      num_q <= req_i.num;
      den_q <= req_i.den;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= qbit ? trial[ipdpc_pkg::DivRemW-1:0] : shifted[ipdpc_pkg::DivRemW-1:0];
      num_q <= {num_q[ipdpc_pkg::DivSteps-2:0], 1'b0};
      quo_q <= {quo_q[ipdpc_pkg::DivSteps-2:0], qbit};
    end
  end

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider restarted while busy");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < den_q))
    else $error("partial remainder not below divisor");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (den_q != '0))
    else $error("division by zero");

endmodule

// ===== design/implicit_pd_position_controller.sv =====
// channel  direction  handshake                  payload
// cfg      in         cfg_we_i (no wait)          cfg_idx_i, cfg_data_i
// in       in         in_valid_i / in_ready_o     bodies_present_i, step_time_i, target/body
// out      out        out_valid_o / out_ready_i   force_valid_o, force_x/y/z_o
//
// One word passes through the gain phase, one pass per axis and the hand-over before
// its result waits; an axis without a velocity division does not wait on the divider.
// A skipped word goes from acceptance straight to the hand-over.
// The one 31-step restoring divider serves the gain phase and every axis.
// A new word is taken while a result still waits; results go out in order.
// Reset restores the gains, clears the previous target and the primed flag.
module implicit_pd_position_controller #(
  parameter int VALUE_WIDTH = ipdpc_pkg::ValueWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ipdpc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ipdpc_pkg::DataW-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             bodies_present_i,
  input  logic [ipdpc_pkg::DtW-1:0]        step_time_i,
  input  logic signed [ipdpc_pkg::DataW-1:0] target_x_i,
  input  logic signed [ipdpc_pkg::DataW-1:0] target_y_i,
  input  logic signed [ipdpc_pkg::DataW-1:0] target_z_i,
  input  logic signed [ipdpc_pkg::DataW-1:0] body_x_i,
  input  logic signed [ipdpc_pkg::DataW-1:0] body_y_i,
  input  logic signed [ipdpc_pkg::DataW-1:0] body_z_i,
  input  logic signed [ipdpc_pkg::DataW-1:0] body_vx_i,
  input  logic signed [ipdpc_pkg::DataW-1:0] body_vy_i,
  input  logic signed [ipdpc_pkg::DataW-1:0] body_vz_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             force_valid_o,
  output logic signed [ipdpc_pkg::DataW-1:0] force_x_o,
  output logic signed [ipdpc_pkg::DataW-1:0] force_y_o,
  output logic signed [ipdpc_pkg::DataW-1:0] force_z_o
);

  localparam int SatW = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
  localparam logic signed [47:0] SatHi = (48'sd1 <<< (SatW - 1)) - 48'sd1;
  localparam logic signed [47:0] SatLo = -SatHi - 48'sd1;

  localparam logic [ipdpc_pkg::DivRemW-1:0] DenBase =
    {{(ipdpc_pkg::DivRemW-33){1'b0}}, 1'b1, 32'b0};
  localparam logic [ipdpc_pkg::DivRemW-1:0] GainRem =
    {{(ipdpc_pkg::DivRemW-32){1'b0}}, 1'b1, 31'b0};

  // gain phase steps
  localparam logic [2:0] G_KPDT  = 3'd0;
  localparam logic [2:0] G_KDDT  = 3'd1;
  localparam logic [2:0] G_DTSQ  = 3'd2;
  localparam logic [2:0] G_DIV   = 3'd3;
  localparam logic [2:0] G_WAIT  = 3'd4;
  localparam logic [2:0] G_KSG   = 3'd5;
  localparam logic [2:0] G_KDG   = 3'd6;
  // axis phase steps
  localparam logic [2:0] A_VEL   = 3'd0;
  localparam logic [2:0] A_WAIT  = 3'd1;
  localparam logic [2:0] A_EKP   = 3'd2;
  localparam logic [2:0] A_SUM   = 3'd3;
  localparam logic [2:0] A_STR   = 3'd4;
  localparam logic [2:0] A_OUT   = 3'd5;

  localparam logic [1:0] LastAxis = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_GAIN = 4'b0010,
    S_AXIS = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    VT_ZERO = 2'd0,
    VT_SAT  = 2'd1,
    VT_QUOT = 2'd2
  } vt_sel_e;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat49(input logic signed [48:0] v);
    if (v[48:31] != {18{v[48]}}) begin
      return v[48] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end
    return v[31:0];
  endfunction

  state_e                       state_q, state_d;
  logic [2:0]                   step_q, step_d;
  logic [1:0]                   axis_q, axis_d;
  logic                         primed_q;
  logic [31:0]                  kp_q, kd_q, str_q;
  logic signed [31:0]           prev_q [3];

  logic                         pres_q;
  logic [ipdpc_pkg::DtW-1:0]    dt_q;
  logic signed [31:0]           tgt_q [3];
  logic signed [31:0]           body_q [3];
  logic signed [31:0]           vel_q [3];

  logic [31:0]                  kpdt_q;
  logic [ipdpc_pkg::DivRemW-1:0] den_q;
  logic [31:0]                  ksg_q, kdg_q;
  logic signed [31:0]           e_q, ev_q, f_q;
  logic signed [47:0]           p1_q;
  logic                         neg_q;
  vt_sel_e                      vt_sel_q;
  logic signed [31:0]           res_q [3];

  logic                         out_valid_q, fvalid_q;
  logic signed [31:0]           fx_q, fy_q, fz_q;

  logic [ipdpc_pkg::MulAW-1:0]  mul_a;
  logic [ipdpc_pkg::MulBW-1:0]  mul_b;
  logic [ipdpc_pkg::ProdW-1:0]  mul_prod;
  ipdpc_pkg::div_req_t          div_req;
  ipdpc_pkg::div_sts_t          div_sts;

  logic signed [32:0]           d_diff, d_mag;
  logic [31:0]                  vmag;
  logic                         vel_ovf, vel_div;
  logic signed [31:0]           e_next, vt_val, ev_next, f_next;
  logic [31:0]                  qext;
  logic                         sgn;
  logic signed [47:0]           pos48, sp, res_wide;
  logic signed [48:0]           sum49;
  logic signed [31:0]           res_next;

  ipdpc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod)
  );

  ipdpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sts_o  (div_sts)
  );

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign force_valid_o = fvalid_q;
  assign force_x_o     = fx_q;
  assign force_y_o     = fy_q;
  assign force_z_o     = fz_q;

  // velocity estimate and error terms of the current axis
  assign d_diff  = {tgt_q[axis_q][31], tgt_q[axis_q]} - {prev_q[axis_q][31], prev_q[axis_q]};
  assign d_mag   = d_diff[32] ? -d_diff : d_diff;
  assign vmag    = d_mag[31:0];
  assign vel_ovf = (vmag >= {1'b0, dt_q, 15'b0});
  assign vel_div = primed_q && (dt_q != '0) && !vel_ovf;
  assign e_next  = sat33({tgt_q[axis_q][31], tgt_q[axis_q]}
                       - {body_q[axis_q][31], body_q[axis_q]});

  assign qext = {1'b0, div_sts.quot};

  always_comb begin
    case (vt_sel_q)
      VT_SAT:  vt_val = neg_q ? 32'sh80000000 : 32'sh7FFFFFFF;
      VT_QUOT: vt_val = neg_q ? -qext : qext;
      default: vt_val = '0;
    endcase
  end

  assign ev_next = sat33({vt_val[31], vt_val} - {vel_q[axis_q][31], vel_q[axis_q]});

  always_comb begin
    case (step_q)
      A_EKP:   sgn = e_q[31];
      A_SUM:   sgn = ev_q[31];
      default: sgn = f_q[31];
    endcase
  end

  assign pos48    = {1'b0, mul_prod[62:16]};
  assign sp       = sgn ? -pos48 : pos48;
  assign sum49    = {p1_q[47], p1_q} + {sp[47], sp};
  assign f_next   = sat49(sum49);
  assign res_wide = (sp > SatHi) ? SatHi : ((sp < SatLo) ? SatLo : sp);
  assign res_next = res_wide[31:0];

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    axis_d  = axis_q;
    div_req = '0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = bodies_present_i ? S_GAIN : S_DONE;
          step_d  = G_KPDT;
          axis_d  = '0;
        end
      end
      S_GAIN: begin
        step_d = step_q + 3'd1;
        case (step_q)
          G_KPDT: begin
            mul_a = {1'b0, kp_q};
            mul_b = {16'b0, dt_q};
          end
          G_KDDT: begin
            mul_a = {1'b0, kd_q};
            mul_b = {16'b0, dt_q};
          end
          G_DTSQ: begin
            mul_a = {1'b0, kpdt_q};
            mul_b = {16'b0, dt_q};
          end
          G_DIV: begin
            div_req.start = 1'b1;
            div_req.rem   = GainRem;
            div_req.num   = '0;
            div_req.den   = den_q + {2'b0, mul_prod[47:0]};
          end
          G_WAIT: begin
            mul_a = {1'b0, kp_q};
            mul_b = qext;
            if (div_sts.busy) begin
              step_d = step_q;
            end
          end
          G_KSG: begin
            mul_a = {1'b0, kd_q} + {1'b0, kpdt_q};
            mul_b = qext;
          end
          G_KDG: begin
            state_d = S_AXIS;
            step_d  = A_VEL;
          end
          default: begin
            state_d = S_IDLE;
            step_d  = G_KPDT;
          end
        endcase
      end
      S_AXIS: begin
        step_d = step_q + 3'd1;
        case (step_q)
          A_VEL: begin
            if (vel_div) begin
              div_req.start = 1'b1;
              div_req.rem   = {{(ipdpc_pkg::DivRemW-17){1'b0}}, vmag[31:15]};
              div_req.num   = {vmag[14:0], 16'b0};
              div_req.den   = {{(ipdpc_pkg::DivRemW-ipdpc_pkg::DtW){1'b0}}, dt_q};
            end
          end
          A_WAIT: begin
            mul_a = {1'b0, mag32(e_q)};
            mul_b = ksg_q;
            if (div_sts.busy) begin
              step_d = step_q;
            end
          end
          A_EKP: begin
            mul_a = {1'b0, mag32(ev_q)};
            mul_b = kdg_q;
          end
          A_SUM: begin
          end
          A_STR: begin
            mul_a = {1'b0, mag32(f_q)};
            mul_b = str_q;
          end
          A_OUT: begin
            if (axis_q == LastAxis) begin
              state_d = S_DONE;
            end else begin
              axis_d = axis_q + 2'd1;
              step_d = A_VEL;
            end
          end
          default: begin
            state_d = S_IDLE;
            step_d  = A_VEL;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      axis_q      <= '0;
      primed_q    <= 1'b0;
      kp_q        <= ipdpc_pkg::KpReset;
      kd_q        <= ipdpc_pkg::KdReset;
      str_q       <= ipdpc_pkg::StrReset;
      prev_q[0]   <= '0;
      prev_q[1]   <= '0;
      prev_q[2]   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      axis_q  <= axis_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ipdpc_pkg::CFG_KP:       kp_q  <= cfg_data_i;
          ipdpc_pkg::CFG_KD:       kd_q  <= cfg_data_i;
          ipdpc_pkg::CFG_STRENGTH: str_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (state_q == S_AXIS && step_q == A_OUT) begin
        prev_q[axis_q] <= tgt_q[axis_q];
        if (axis_q == LastAxis) begin
          primed_q <= 1'b1;
        end
      end
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pres_q    <= bodies_present_i;
          dt_q      <= step_time_i;
          tgt_q[0]  <= target_x_i;
          tgt_q[1]  <= target_y_i;
          tgt_q[2]  <= target_z_i;
          body_q[0] <= body_x_i;
          body_q[1] <= body_y_i;
          body_q[2] <= body_z_i;
          vel_q[0]  <= body_vx_i;
          vel_q[1]  <= body_vy_i;
          vel_q[2]  <= body_vz_i;
        end
      end
      S_GAIN: begin
        case (step_q)
          G_KDDT: kpdt_q <= mul_prod[47:16];
          G_DTSQ: den_q  <= DenBase + {2'b0, mul_prod[47:0]};
          G_KSG:  ksg_q  <= mul_prod[61:30];
          G_KDG:  kdg_q  <= (mul_prod[63:62] != 2'b00) ? 32'hFFFFFFFF : mul_prod[61:30];
          default: begin
          end
        endcase
      end
      S_AXIS: begin
        case (step_q)
          A_VEL: begin
            e_q   <= e_next;
            neg_q <= d_diff[32];
            if (!primed_q || dt_q == '0) begin
              vt_sel_q <= VT_ZERO;
            end else if (vel_ovf) begin
              vt_sel_q <= VT_SAT;
            end else begin
              vt_sel_q <= VT_QUOT;
            end
          end
          A_WAIT: begin
            if (!div_sts.busy) begin
              ev_q <= ev_next;
            end
          end
          A_EKP: p1_q <= sp;
          A_SUM: f_q  <= f_next;
          A_OUT: res_q[axis_q] <= res_next;
          default: begin
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          fvalid_q <= pres_q;
          fx_q     <= pres_q ? res_q[0] : '0;
          fy_q     <= pres_q ? res_q[1] : '0;
          fz_q     <= pres_q ? res_q[2] : '0;
        end
      end
      default: begin
      end
    endcase
  end

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AXIS) |-> (axis_q <= LastAxis))
    else $error("axis index out of range");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !div_sts.busy)
    else $error("divider busy outside an item");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result word raised outside hand-over");

endmodule
